@@ rtl/lpcp_pkg.sv @@
// ----------------------------------------------------------------------------
// lpcp_pkg
// shared types, constants and coefficient tables of the lidar point projector
// ----------------------------------------------------------------------------
package lpcp_pkg;

    localparam int IMAGE_WIDTH_DEF  = 640;
    localparam int IMAGE_HEIGHT_DEF = 480;

    localparam logic [15:0] RANGE_MIN   = 16'd100;
    localparam logic [15:0] RANGE_MAX   = 16'd6000;
    localparam logic [15:0] ANGLE_LIMIT = 16'd9102;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    // widths of the datapath
    localparam int XW   = 30;   // angle in radians, q30
    localparam int SW   = 31;   // series value, q30, up to one
    localparam int DW   = 47;   // divisor
    localparam int NUMW = 60;   // dividend
    localparam int QW   = 13;   // quotient

    localparam int SIN_CELLS = 4;
    localparam int COS_CELLS = 5;
    localparam int HORNER_LAT = 3;

    // latency of one camera lane, from its angle input to its result
    localparam int CAM_LAT = 2 + COS_CELLS * HORNER_LAT + 3 + QW + 1;

    // register indexes of the configuration port
    localparam logic [3:0] CFG_FRONT_OFS   = 4'd0;
    localparam logic [3:0] CFG_REAR_OFS    = 4'd1;
    localparam logic [3:0] CFG_FRONT_HGAIN = 4'd2;
    localparam logic [3:0] CFG_FRONT_VGAIN = 4'd3;
    localparam logic [3:0] CFG_REAR_HGAIN  = 4'd4;
    localparam logic [3:0] CFG_REAR_VGAIN  = 4'd5;
    localparam logic [3:0] CFG_FRONT_CTR   = 4'd6;
    localparam logic [3:0] CFG_REAR_CTR    = 4'd7;

    localparam logic [15:0] RST_FRONT_OFS   = 16'hFF10;
    localparam logic [15:0] RST_REAR_OFS    = 16'hFF10;
    localparam logic [15:0] RST_FRONT_HGAIN = 16'd34457;
    localparam logic [18:0] RST_FRONT_VGAIN = 19'h6C54B;
    localparam logic [15:0] RST_REAR_HGAIN  = 16'd35647;
    localparam logic [18:0] RST_REAR_VGAIN  = 19'h6BA50;
    localparam logic [19:0] RST_FRONT_CTR   = 20'd260406;
    localparam logic [19:0] RST_REAR_CTR    = 20'd257340;

    typedef struct packed {
        logic [15:0]        range_mm;
        logic signed [15:0] bearing;
    } t_point;

    typedef struct packed {
        logic        front_hit;
        logic [9:0]  front_u;
        logic [8:0]  front_v;
        logic        rear_hit;
        logic [9:0]  rear_u;
        logic [8:0]  rear_v;
        logic [15:0] range_out;
    } t_result;

    // horner divisors, innermost term first
    function automatic int sin_k(input int i);
        int k;
        unique case (i)
            0:       k = 72;
            1:       k = 42;
            2:       k = 20;
            default: k = 6;
        endcase
        return k;
    endfunction

    function automatic int cos_k(input int i);
        int k;
        unique case (i)
            0:       k = 90;
            1:       k = 56;
            2:       k = 30;
            3:       k = 12;
            default: k = 2;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/lpcp_horner_cell.sv @@
// ----------------------------------------------------------------------------
// lpcp_horner_cell
// one horner step s' = 1 - ((x2 * s) >> 30) / K over three stages
// ----------------------------------------------------------------------------
module lpcp_horner_cell #(
    parameter int K = 2
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [lpcp_pkg::XW-1:0]  i_x2,
    input  logic [lpcp_pkg::SW-1:0]  i_s,
    output logic [lpcp_pkg::XW-1:0]  o_x2,
    output logic [lpcp_pkg::SW-1:0]  o_s
);

    localparam int XW = lpcp_pkg::XW;
    localparam int SW = lpcp_pkg::SW;
    localparam int PW = XW + SW;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);

    logic [XW-1:0] r_x2a, r_x2b;
    logic [PW-1:0] r_p;
    logic [SW-1:0] r_t;
    logic [SW+31:0] r_qp;

    logic [SW-1:0] w_q0, w_rem, w_q;

    // reciprocal estimate is low by at most one
    assign w_q0  = r_qp[SW+31:32];
    assign w_rem = r_t - SW'(w_q0 * SW'(K));
    assign w_q   = (w_rem >= SW'(K)) ? w_q0 + SW'(1) : w_q0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2a <= i_x2;
            r_p   <= PW'(i_x2) * PW'(i_s);
            r_x2b <= r_x2a;
            r_t   <= r_p[PW-1:30];
            r_qp  <= (SW+32)'(r_p[PW-1:30]) * (SW+32)'(RECIP);
            o_x2  <= r_x2b;
            o_s   <= lpcp_pkg::ONE_Q30 - w_q;
        end
    end

endmodule

@@ rtl/lpcp_div_cell.sv @@
// ----------------------------------------------------------------------------
// lpcp_div_cell
// one restoring division step, quotient bit SH
// ----------------------------------------------------------------------------
module lpcp_div_cell #(
    parameter int SH = 0
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [lpcp_pkg::NUMW-1:0]  i_rem,
    input  logic [lpcp_pkg::DW-1:0]    i_den,
    input  logic [lpcp_pkg::QW-1:0]    i_q,
    output logic [lpcp_pkg::NUMW-1:0]  o_rem,
    output logic [lpcp_pkg::DW-1:0]    o_den,
    output logic [lpcp_pkg::QW-1:0]    o_q
);

    localparam int NUMW = lpcp_pkg::NUMW;

    logic [NUMW-1:0]        w_dsh;
    logic                   w_ge;
    logic [lpcp_pkg::QW-1:0] w_q;

    assign w_dsh = NUMW'(i_den) << SH;
    assign w_ge  = (i_rem >= w_dsh);

    always_comb begin
        w_q     = i_q;
        w_q[SH] = w_ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= w_ge ? i_rem - w_dsh : i_rem;
            o_den <= i_den;
            o_q   <= w_q;
        end
    end

endmodule

@@ rtl/lpcp_camera.sv @@
// ----------------------------------------------------------------------------
// lpcp_camera
// one camera lane: series sin and cos, pinhole products, two long divisions
// ----------------------------------------------------------------------------
module lpcp_camera #(
    parameter int IMAGE_WIDTH  = lpcp_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = lpcp_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    input  logic [15:0]        i_range,
    input  logic [15:0]        i_hgain,
    input  logic signed [18:0] i_vgain,
    input  logic [19:0]        i_center,
    output logic               o_hit,
    output logic [9:0]         o_u,
    output logic [8:0]         o_v
);

    localparam int XW   = lpcp_pkg::XW;
    localparam int SW   = lpcp_pkg::SW;
    localparam int DW   = lpcp_pkg::DW;
    localparam int NUMW = lpcp_pkg::NUMW;
    localparam int QW   = lpcp_pkg::QW;
    localparam int NS   = lpcp_pkg::SIN_CELLS;
    localparam int NC   = lpcp_pkg::COS_CELLS;
    localparam int SLAT = NC * lpcp_pkg::HORNER_LAT;
    localparam int DLY  = (NC - NS) * lpcp_pkg::HORNER_LAT;
    localparam logic [QW-1:0] WLIM = QW'(IMAGE_WIDTH);
    localparam logic [QW-1:0] HLIM = QW'(IMAGE_HEIGHT);

    typedef struct packed {
        logic [XW-1:0] x;
        logic          neg;
        logic          win;
        logic [15:0]   rng;
    } t_side;

    typedef struct packed {
        logic negu;
        logic negv;
        logic win;
    } t_dside;

    // stage a: magnitude and angle in radians
    logic        w_neg;
    logic [15:0] w_mag;
    logic [47:0] r_a_xp;
    logic        r_a_neg, r_a_win;
    logic [15:0] r_a_rng;

    assign w_neg = i_angle[15];
    assign w_mag = w_neg ? 16'(-i_angle) : 16'(i_angle);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_xp  <= 48'(w_mag) * 48'(lpcp_pkg::PI_Q30);
            r_a_neg <= w_neg;
            r_a_win <= (w_mag <= lpcp_pkg::ANGLE_LIMIT);
            r_a_rng <= i_range;
        end
    end

    // stage b: square of the angle
    logic [XW-1:0]   r_b_x;
    logic [2*XW-1:0] r_b_x2p;
    logic            r_b_neg, r_b_win;
    logic [15:0]     r_b_rng;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_x   <= r_a_xp[XW+14:15];
            r_b_x2p <= (2*XW)'(r_a_xp[XW+14:15]) * (2*XW)'(r_a_xp[XW+14:15]);
            r_b_neg <= r_a_neg;
            r_b_win <= r_a_win;
            r_b_rng <= r_a_rng;
        end
    end

    // horner chains
    logic [XW-1:0] w_sx2 [NS+1];
    logic [SW-1:0] w_ss  [NS+1];
    logic [XW-1:0] w_cx2 [NC+1];
    logic [SW-1:0] w_cs  [NC+1];

    assign w_sx2[0] = r_b_x2p[2*XW-1:30];
    assign w_ss[0]  = lpcp_pkg::ONE_Q30;
    assign w_cx2[0] = r_b_x2p[2*XW-1:30];
    assign w_cs[0]  = lpcp_pkg::ONE_Q30;

    for (genvar g = 0; g < NS; g++) begin : g_sin
        lpcp_horner_cell #(.K(lpcp_pkg::sin_k(g))) u_cell (
            .i_clk (i_clk), .i_en (i_en),
            .i_x2  (w_sx2[g]), .i_s (w_ss[g]),
            .o_x2  (w_sx2[g+1]), .o_s (w_ss[g+1])
        );
    end

    for (genvar g = 0; g < NC; g++) begin : g_cos
        lpcp_horner_cell #(.K(lpcp_pkg::cos_k(g))) u_cell (
            .i_clk (i_clk), .i_en (i_en),
            .i_x2  (w_cx2[g]), .i_s (w_cs[g]),
            .o_x2  (w_cx2[g+1]), .o_s (w_cs[g+1])
        );
    end

    // sidecar alongside the chains, sin result delayed to meet cos
    t_side         r_sd   [SLAT];
    logic [SW-1:0] r_sdly [DLY];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= '{x: r_b_x, neg: r_b_neg, win: r_b_win, rng: r_b_rng};
            for (int k = 1; k < SLAT; k++) r_sd[k] <= r_sd[k-1];
            r_sdly[0] <= w_ss[NS];
            for (int k = 1; k < DLY; k++) r_sdly[k] <= r_sdly[k-1];
        end
    end

    // stage d: sine magnitude, vertical divisor
    logic [XW+SW-1:0] r_d_smp;
    logic [SW-1:0]    r_d_c;
    logic [DW-1:0]    r_d_denv;
    logic             r_d_neg, r_d_win;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_smp  <= (XW+SW)'(r_sd[SLAT-1].x) * (XW+SW)'(r_sdly[DLY-1]);
            r_d_c    <= w_cs[NC];
            r_d_denv <= DW'(r_sd[SLAT-1].rng) * DW'(w_cs[NC]);
            r_d_neg  <= r_sd[SLAT-1].neg;
            r_d_win  <= r_sd[SLAT-1].win;
        end
    end

    // stage e: gain and centre products
    logic signed [SW:0]  w_sn;
    logic signed [48:0]  r_e_a;
    logic [SW+9:0]       r_e_cxc;
    logic [DW+9:0]       r_e_cyd;
    logic [SW+5:0]       r_e_denu;
    logic [DW-1:0]       r_e_denv;
    logic                r_e_win;

    assign w_sn = r_d_neg ? -$signed({1'b0, r_d_smp[XW+SW-1:30]})
                          :  $signed({1'b0, r_d_smp[XW+SW-1:30]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_a    <= $signed({1'b0, i_hgain}) * w_sn;
            r_e_cxc  <= (SW+10)'(i_center[9:0]) * (SW+10)'(r_d_c);
            r_e_cyd  <= (DW+10)'(i_center[19:10]) * (DW+10)'(r_d_denv);
            r_e_denu <= {r_d_c, 6'b0};
            r_e_denv <= r_d_denv;
            r_e_win  <= r_d_win;
        end
    end

    // stage f: dividends, split into sign and magnitude
    logic signed [NUMW-1:0] w_numu, w_numv;
    logic [NUMW-1:0]        r_f_remu, r_f_remv;
    logic [DW-1:0]          r_f_denu, r_f_denv;
    t_dside                 r_f_side;

    assign w_numu = NUMW'(r_e_a) + $signed(NUMW'({r_e_cxc, 6'b0}));
    assign w_numv = (NUMW'(i_vgain) <<< 30) + $signed(NUMW'(r_e_cyd));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_remu <= w_numu[NUMW-1] ? NUMW'(-w_numu) : NUMW'(w_numu);
            r_f_remv <= w_numv[NUMW-1] ? NUMW'(-w_numv) : NUMW'(w_numv);
            r_f_denu <= DW'(r_e_denu);
            r_f_denv <= r_e_denv;
            r_f_side <= '{negu: w_numu[NUMW-1], negv: w_numv[NUMW-1], win: r_e_win};
        end
    end

    // division chains, most significant quotient bit first
    logic [NUMW-1:0] w_ru [QW+1];
    logic [DW-1:0]   w_du [QW+1];
    logic [QW-1:0]   w_qu [QW+1];
    logic [NUMW-1:0] w_rv [QW+1];
    logic [DW-1:0]   w_dv [QW+1];
    logic [QW-1:0]   w_qv [QW+1];
    t_dside          r_dsd [QW];

    assign w_ru[0] = r_f_remu;
    assign w_du[0] = r_f_denu;
    assign w_qu[0] = '0;
    assign w_rv[0] = r_f_remv;
    assign w_dv[0] = r_f_denv;
    assign w_qv[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_div
        lpcp_div_cell #(.SH(QW - 1 - g)) u_du (
            .i_clk (i_clk), .i_en (i_en),
            .i_rem (w_ru[g]), .i_den (w_du[g]), .i_q (w_qu[g]),
            .o_rem (w_ru[g+1]), .o_den (w_du[g+1]), .o_q (w_qu[g+1])
        );
        lpcp_div_cell #(.SH(QW - 1 - g)) u_dv (
            .i_clk (i_clk), .i_en (i_en),
            .i_rem (w_rv[g]), .i_den (w_dv[g]), .i_q (w_qv[g]),
            .o_rem (w_rv[g+1]), .o_den (w_dv[g+1]), .o_q (w_qv[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dsd[0] <= r_f_side;
            for (int k = 1; k < QW; k++) r_dsd[k] <= r_dsd[k-1];
        end
    end

    // stage g: bounds check, truncation toward zero
    logic w_hit;

    assign w_hit = r_dsd[QW-1].win
                 && (!r_dsd[QW-1].negu || (w_qu[QW] == '0)) && (w_qu[QW] < WLIM)
                 && (!r_dsd[QW-1].negv || (w_qv[QW] == '0)) && (w_qv[QW] < HLIM);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit <= w_hit;
            o_u   <= w_hit ? w_qu[QW][9:0] : 10'd0;
            o_v   <= w_hit ? w_qv[QW][8:0] : 9'd0;
        end
    end

endmodule

@@ rtl/lidar_point_camera_projector.sv @@
// ----------------------------------------------------------------------------
// lidar_point_camera_projector
// projects one lidar point into the front and rear camera images
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  point     in         i_valid / o_stall    i_point  (t_point)
//  result    out        o_valid / i_stall    o_result (t_result)
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
//  one request accepted per cycle while the output register is free or being taken; a
//  request passes the input stage, the horner cell chain and the 13 bit division chain
//  a stall on the output freezes the whole pipeline, bubbles included
//  synchronous active low reset clears the valid bits and loads the register
//  reset values; the datapath carries no reset
// ----------------------------------------------------------------------------
module lidar_point_camera_projector #(
    parameter int IMAGE_WIDTH  = lpcp_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = lpcp_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  lpcp_pkg::t_point  i_point,
    output logic              o_valid,
    input  logic              i_stall,
    output lpcp_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_idx,
    input  logic [19:0]       i_cfg_data
);

    localparam int LAT = lpcp_pkg::CAM_LAT;

    // configuration registers
    logic [15:0]        r_front_ofs, r_rear_ofs;
    logic [15:0]        r_front_hgain, r_rear_hgain;
    logic signed [18:0] r_front_vgain, r_rear_vgain;
    logic [19:0]        r_front_ctr, r_rear_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_ofs   <= lpcp_pkg::RST_FRONT_OFS;
            r_rear_ofs    <= lpcp_pkg::RST_REAR_OFS;
            r_front_hgain <= lpcp_pkg::RST_FRONT_HGAIN;
            r_front_vgain <= lpcp_pkg::RST_FRONT_VGAIN;
            r_rear_hgain  <= lpcp_pkg::RST_REAR_HGAIN;
            r_rear_vgain  <= lpcp_pkg::RST_REAR_VGAIN;
            r_front_ctr   <= lpcp_pkg::RST_FRONT_CTR;
            r_rear_ctr    <= lpcp_pkg::RST_REAR_CTR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpcp_pkg::CFG_FRONT_OFS:   r_front_ofs   <= i_cfg_data[15:0];
                lpcp_pkg::CFG_REAR_OFS:    r_rear_ofs    <= i_cfg_data[15:0];
                lpcp_pkg::CFG_FRONT_HGAIN: r_front_hgain <= i_cfg_data[15:0];
                lpcp_pkg::CFG_FRONT_VGAIN: r_front_vgain <= i_cfg_data[18:0];
                lpcp_pkg::CFG_REAR_HGAIN:  r_rear_hgain  <= i_cfg_data[15:0];
                lpcp_pkg::CFG_REAR_VGAIN:  r_rear_vgain  <= i_cfg_data[18:0];
                lpcp_pkg::CFG_FRONT_CTR:   r_front_ctr   <= i_cfg_data;
                lpcp_pkg::CFG_REAR_CTR:    r_rear_ctr    <= i_cfg_data;
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // pipeline advances whenever the output register is free or being taken
    logic           w_en;
    logic [LAT:0]   r_vld;
    logic [LAT:0]   r_rwin;
    logic [15:0]    r_rng [LAT+1];
    logic [15:0]    r_af, r_ar;

    assign w_en    = !r_vld[LAT] || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-1:0], i_valid};
        end
    end

    // input stage: mounting corrections, wrap modulo a full turn
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_af     <= 16'(i_point.bearing) + r_front_ofs;
            r_ar     <= 16'(i_point.bearing) + 16'h8000 + r_rear_ofs;
            r_rng[0] <= i_point.range_mm;
            r_rwin   <= {r_rwin[LAT-1:0], (i_point.range_mm >= lpcp_pkg::RANGE_MIN)
                                         && (i_point.range_mm <= lpcp_pkg::RANGE_MAX)};
            for (int k = 1; k <= LAT; k++) r_rng[k] <= r_rng[k-1];
        end
    end

    logic       w_fh, w_rh;
    logic [9:0] w_fu, w_ru;
    logic [8:0] w_fv, w_rv;

    lpcp_camera #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_front (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_angle  ($signed(r_af)),
        .i_range  (r_rng[0]),
        .i_hgain  (r_front_hgain),
        .i_vgain  (r_front_vgain),
        .i_center (r_front_ctr),
        .o_hit    (w_fh),
        .o_u      (w_fu),
        .o_v      (w_fv)
    );

    lpcp_camera #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_rear (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_angle  ($signed(r_ar)),
        .i_range  (r_rng[0]),
        .i_hgain  (r_rear_hgain),
        .i_vgain  (r_rear_vgain),
        .i_center (r_rear_ctr),
        .o_hit    (w_rh),
        .o_u      (w_ru),
        .o_v      (w_rv)
    );

    // range outside the window masks both cameras
    assign o_result.front_hit = w_fh && r_rwin[LAT];
    assign o_result.front_u   = r_rwin[LAT] ? w_fu : 10'd0;
    assign o_result.front_v   = r_rwin[LAT] ? w_fv : 9'd0;
    assign o_result.rear_hit  = w_rh && r_rwin[LAT];
    assign o_result.rear_u    = r_rwin[LAT] ? w_ru : 10'd0;
    assign o_result.rear_v    = r_rwin[LAT] ? w_rv : 9'd0;
    assign o_result.range_out = r_rng[LAT];

    // checks
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with empty output register");

    a_front_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.front_hit) |->
            (o_result.front_u == 10'd0 && o_result.front_v == 9'd0))
        else $error("front pixel not cleared on a miss");

    a_front_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.front_hit) |->
            (32'(o_result.front_u) < IMAGE_WIDTH && 32'(o_result.front_v) < IMAGE_HEIGHT))
        else $error("front hit outside the image");

    a_range_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.range_out < lpcp_pkg::RANGE_MIN
                     || o_result.range_out > lpcp_pkg::RANGE_MAX)) |->
            (!o_result.front_hit && !o_result.rear_hit))
        else $error("hit reported for a range outside the window");

endmodule

@@ verif/lpcp_checker.sv @@
// ----------------------------------------------------------------------------
// lpcp_checker
// watches the point, result and config channels of the projector, predicts
// each result from its own copy of the registers and compares field by field
// ----------------------------------------------------------------------------
module lpcp_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_o_stall,
    input  lpcp_pkg::t_point  i_point,
    input  logic              i_o_valid,
    input  logic              i_stall,
    input  lpcp_pkg::t_result i_result,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_idx,
    input  logic [19:0]       i_cfg_data,
    output int                o_pending,
    output int                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] front_ofs, rear_ofs, front_hgain, rear_hgain;
    logic [18:0] front_vgain, rear_vgain;
    logic [19:0] front_ctr, rear_ctr;

    lpcp_pkg::t_result expected_results[$];

    function automatic longint unsigned horner_q30(longint unsigned x2, bit is_cos);
        int unsigned k[5];
        int n;
        longint unsigned s;
        if (is_cos) begin
            k = '{90, 56, 30, 12, 2};
            n = 5;
        end else begin
            k = '{72, 42, 20, 6, 1};
            n = 4;
        end
        s = 64'(lpcp_pkg::ONE_Q30) - x2 / k[0];
        for (int i = 1; i < n; i++) begin
            s = 64'(lpcp_pkg::ONE_Q30) - ((x2 * s) >> 30) / k[i];
        end
        return s;
    endfunction

    // pinhole projection of one corrected angle into one camera
    function automatic void project_pixel(
        input  logic [15:0] angle,
        input  logic [15:0] range_mm,
        input  logic [15:0] hgain,
        input  logic [18:0] vgain_raw,
        input  logic [19:0] ctr,
        output logic        hit,
        output logic [9:0]  pu,
        output logic [8:0]  pv
    );
        longint a, m, sn, cx, cy, vgain, num, den, u, v;
        longint unsigned x, x2, smag, c;
        a = longint'($signed(angle));
        m = (a < 0) ? -a : a;
        hit = 1'b0;
        pu = '0;
        pv = '0;
        if (m > longint'(lpcp_pkg::ANGLE_LIMIT)) return;
        x = (unsigned'(m) * 64'(lpcp_pkg::PI_Q30)) >> 15;
        x2 = (x * x) >> 30;
        smag = (x * horner_q30(x2, 1'b0)) >> 30;
        c = horner_q30(x2, 1'b1);
        sn = (a < 0) ? -longint'(smag) : longint'(smag);
        cx = longint'(ctr[9:0]);
        cy = longint'(ctr[19:10]);
        vgain = longint'($signed(vgain_raw));
        den = longint'(c) * 64;
        num = longint'(hgain) * sn + cx * den;
        u = num / den;
        den = longint'(range_mm) * longint'(c);
        num = vgain * longint'(lpcp_pkg::ONE_Q30) + cy * den;
        v = num / den;
        if (u < 0 || u >= lpcp_pkg::IMAGE_WIDTH_DEF || v < 0
            || v >= lpcp_pkg::IMAGE_HEIGHT_DEF) return;
        hit = 1'b1;
        pu = u[9:0];
        pv = v[8:0];
    endfunction

    function automatic lpcp_pkg::t_result predict_pixels(lpcp_pkg::t_point p);
        lpcp_pkg::t_result r;
        r = '0;
        r.range_out = p.range_mm;
        if (p.range_mm >= lpcp_pkg::RANGE_MIN && p.range_mm <= lpcp_pkg::RANGE_MAX) begin
            project_pixel(p.bearing + front_ofs, p.range_mm, front_hgain, front_vgain,
                          front_ctr, r.front_hit, r.front_u, r.front_v);
            project_pixel(p.bearing + 16'h8000 + rear_ofs, p.range_mm, rear_hgain,
                          rear_vgain, rear_ctr, r.rear_hit, r.rear_u, r.rear_v);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        lpcp_pkg::t_result exp_r;
        if (!i_rst_n) begin
            front_ofs   <= lpcp_pkg::RST_FRONT_OFS;
            rear_ofs    <= lpcp_pkg::RST_REAR_OFS;
            front_hgain <= lpcp_pkg::RST_FRONT_HGAIN;
            front_vgain <= lpcp_pkg::RST_FRONT_VGAIN;
            rear_hgain  <= lpcp_pkg::RST_REAR_HGAIN;
            rear_vgain  <= lpcp_pkg::RST_REAR_VGAIN;
            front_ctr   <= lpcp_pkg::RST_FRONT_CTR;
            rear_ctr    <= lpcp_pkg::RST_REAR_CTR;
            expected_results.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lpcp_pkg::CFG_FRONT_OFS:   front_ofs   <= i_cfg_data[15:0];
                    lpcp_pkg::CFG_REAR_OFS:    rear_ofs    <= i_cfg_data[15:0];
                    lpcp_pkg::CFG_FRONT_HGAIN: front_hgain <= i_cfg_data[15:0];
                    lpcp_pkg::CFG_FRONT_VGAIN: front_vgain <= i_cfg_data[18:0];
                    lpcp_pkg::CFG_REAR_HGAIN:  rear_hgain  <= i_cfg_data[15:0];
                    lpcp_pkg::CFG_REAR_VGAIN:  rear_vgain  <= i_cfg_data[18:0];
                    lpcp_pkg::CFG_FRONT_CTR:   front_ctr   <= i_cfg_data;
                    lpcp_pkg::CFG_REAR_CTR:    rear_ctr    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_o_stall)
                expected_results = {expected_results, predict_pixels(i_point)};
            if (i_o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result %p", i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== i_result) begin
                        o_fail_count <= o_fail_count + 1;
                        if (exp_r.front_hit !== i_result.front_hit)
                            $error("front_hit exp %0d got %0d", exp_r.front_hit, i_result.front_hit);
                        if (exp_r.front_u !== i_result.front_u)
                            $error("front_u exp %0d got %0d", exp_r.front_u, i_result.front_u);
                        if (exp_r.front_v !== i_result.front_v)
                            $error("front_v exp %0d got %0d", exp_r.front_v, i_result.front_v);
                        if (exp_r.rear_hit !== i_result.rear_hit)
                            $error("rear_hit exp %0d got %0d", exp_r.rear_hit, i_result.rear_hit);
                        if (exp_r.rear_u !== i_result.rear_u)
                            $error("rear_u exp %0d got %0d", exp_r.rear_u, i_result.rear_u);
                        if (exp_r.rear_v !== i_result.rear_v)
                            $error("rear_v exp %0d got %0d", exp_r.rear_v, i_result.rear_v);
                        if (exp_r.range_out !== i_result.range_out)
                            $error("range_out exp %0d got %0d", exp_r.range_out,
                                   i_result.range_out);
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// drives points and register settings into the lidar projector under random
// idling on both channels; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         PHASE_ITEMS    = 210;
    localparam logic [3:0] CFG_UNUSED     = 4'd9;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    lpcp_pkg::t_point  i_point = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    lpcp_pkg::t_result o_result;
    logic              i_cfg_we = 1'b0;
    logic [3:0]        i_cfg_idx = '0;
    logic [19:0]       i_cfg_data = '0;
    int                pending, fail_count;

    // idle percentages of sender and receiver, changed every second phase
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req = 0;
    int idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    lidar_point_camera_projector u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_point,
        .o_valid, .i_stall, .o_result, .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    lpcp_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_o_stall(o_stall), .i_point,
        .i_o_valid(o_valid), .i_stall, .i_result(o_result),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_pending(pending), .o_fail_count(fail_count)
    );

    // receiver: random stall, or a long hold-off when asked
    always @(posedge i_clk) begin
        int hold_left;
        if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_point(logic [15:0] range_mm, logic [15:0] bearing);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point <= '{range_mm: range_mm, bearing: bearing};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // registers are only written with the pipeline drained
    task automatic write_regs(logic [19:0] vals[8]);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 4'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        // out-of-range index must be ignored
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= 20'($urandom());
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly in-window points aimed at one of the cameras, some noise
    task automatic send_random_point(logic [15:0] front_ofs, logic [15:0] rear_ofs);
        logic [15:0] r, b;
        int sel;
        sel = $urandom_range(9);
        r = 16'($urandom_range(6000, 100));
        if (sel < 4)      b = 16'($urandom_range(19000)) - 16'd9500 - front_ofs;
        else if (sel < 8) b = 16'($urandom_range(19000)) - 16'd9500 - 16'h8000 - rear_ofs;
        else begin
            b = 16'($urandom());
            if (sel == 9) r = 16'($urandom());
        end
        send_point(r, b);
    endtask

    initial begin
        logic [19:0] regs[8];
        logic [15:0] fo, ro;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: range edges, bearing extremes and window edges at reset values
        send_point(16'd0, 16'd0);
        send_point(16'd99, 16'd240);
        send_point(16'd100, 16'd240);
        send_point(16'd6000, 16'd240);
        send_point(16'd6001, 16'd240);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'd1000, 16'h8000);
        send_point(16'd1000, 16'h7FFF);
        send_point(16'd1000, 16'd240 + 16'd9102);
        send_point(16'd1000, 16'd240 + 16'd9103);
        send_point(16'd1000, 16'd240 - 16'd9102);
        send_point(16'd1000, 16'd240 - 16'd9103);
        send_point(16'd500, 16'h80F0);
        send_point(16'd100, 16'h80F0 + 16'd9102);
        send_point(16'd100, 16'h80F0 - 16'd9102);
        send_point(16'd3000, 16'h5555);
        send_point(16'd3000, 16'hAAAA);

        for (int phase = 0; phase < 6; phase++) begin
            unique case (phase / 2)
                0: begin tx_idle_pct = 26; rx_idle_pct = 81; end
                1: begin tx_idle_pct = 81; rx_idle_pct = 26; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (phase == 1) begin
                // extremes: offsets, gains and centres at their limits
                regs = '{20'h08000, 20'h07FFF, 20'h0FFFF, 20'h40000,
                         20'h00000, 20'h3FFFF, 20'hFFFFF, 20'h00000};
            end else if (phase == 4) begin
                regs = '{20'h07FFF, 20'h08000, 20'h00000, 20'h3FFFF,
                         20'h0FFFF, 20'h40000, 20'h00000, 20'hFFFFF};
            end else begin
                for (int i = 0; i < 8; i++) regs[i] = 20'($urandom());
                // keep principal points and gains near real cameras mostly
                regs[lpcp_pkg::CFG_FRONT_HGAIN[2:0]] = 20'($urandom_range(45000, 20000));
                regs[lpcp_pkg::CFG_REAR_HGAIN[2:0]]  = 20'($urandom_range(45000, 20000));
                regs[lpcp_pkg::CFG_FRONT_VGAIN[2:0]] = 20'(-$urandom_range(150000, 20000));
                regs[lpcp_pkg::CFG_REAR_VGAIN[2:0]]  = 20'($urandom_range(150000, 20000));
                regs[lpcp_pkg::CFG_FRONT_CTR[2:0]]   = {10'($urandom_range(300, 150)),
                                                        10'($urandom_range(400, 250))};
                regs[lpcp_pkg::CFG_REAR_CTR[2:0]]    = {10'($urandom_range(300, 150)),
                                                        10'($urandom_range(400, 250))};
            end
            write_regs(regs);
            fo = regs[lpcp_pkg::CFG_FRONT_OFS[2:0]][15:0];
            ro = regs[lpcp_pkg::CFG_REAR_OFS[2:0]][15:0];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // fill the pipeline against a long hold-off once per phase
                if (n == 20) hold_req = 1;
                send_random_point(fo, ro);
            end
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lpcp_pkg.sv
rtl/lpcp_horner_cell.sv
rtl/lpcp_div_cell.sv
rtl/lpcp_camera.sv
rtl/lidar_point_camera_projector.sv
verif/lpcp_checker.sv
verif/tb_top.sv
